// ----- rtl/ubfit_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubfit_pkg
// Shared types, sizes and codes of the buffered UART frame idle timeout core.
// ----------------------------------------------------------------------------
package ubfit_pkg;

  localparam int unsigned TX_DEPTH = 256;
  localparam int unsigned RX_DEPTH = 256;
  localparam int unsigned MAX_READ = 64;

  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned DRN_W = $clog2(MAX_READ + 1);

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned GAP_W    = 8;
  localparam int unsigned STATUS_W = 2;

  // Stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 2;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_IDLE_GAP = 2'd0;
  localparam logic [1:0] REG_RX_EN    = 2'd1;
  localparam logic [1:0] REG_TX_EN    = 2'd2;

  localparam logic [GAP_W-1:0] IDLE_GAP_RST = 8'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_RX_BYTE  = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_TX_WRITE = 3'd2,
    KIND_HOST_RD  = 3'd3,
    KIND_TX_DONE  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    RX_IDLE = 2'd0,
    RX_RECV = 2'd1,
    RX_DONE = 2'd2
  } rx_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic             rx_en;
    logic             tx_en;
    logic [GAP_W-1:0] idle_gap;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic start_drain;
    logic drain_pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_drain_read;
    logic drain_last;
    logic out_free;
  } dp_status_t;

endpackage : ubfit_pkg
`default_nettype wire

// ----- rtl/ubfit_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubfit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ubfit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : ubfit_ram
`default_nettype wire

// ----- rtl/ubfit_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubfit_ctrl
// Item sequencer: accept, execute one step, or drain a host read.
// ----------------------------------------------------------------------------
module ubfit_ctrl
  import ubfit_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_drain_read) begin
          state_d = ST_DRAIN;
        end else if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (status_i.out_free && status_i.drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: begin
        if (status_i.is_drain_read) begin
          cmd_o.start_drain = 1'b1;
        end else begin
          cmd_o.exec = status_i.out_free;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain_pop = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule : ubfit_ctrl
`default_nettype wire

// ----- rtl/ubfit_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubfit_dp
// Datapath: FIFO pointers and stores, gap timer, transmitter flag, result register.
// ----------------------------------------------------------------------------
module ubfit_dp
  import ubfit_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire ctrl_cmd_t            cmd_i,
  output dp_status_t                status_o,
  input  wire logic [S_TDATA_W-1:0] in_tdata_i,
  input  wire logic [S_TUSER_W-1:0] in_tuser_i,
  output logic                      out_tvalid_o,
  input  wire logic                 out_tready_i,
  output logic      [M_TDATA_W-1:0] out_tdata_o,
  output logic      [M_TUSER_W-1:0] out_tuser_o,
  output logic                      out_tlast_o
);

  // Latched item
  logic [KIND_W-1:0] kind_q;
  logic [BYTE_W-1:0] data_q;
  logic [LEN_W-1:0]  len_q;

  // Queue and timer state
  logic [RX_AW-1:0] rx_head_q, rx_head_d;
  logic [RX_CW-1:0] rx_fill_q, rx_fill_d;
  logic [TX_AW-1:0] tx_head_q, tx_head_d;
  logic [TX_CW-1:0] tx_fill_q, tx_fill_d;
  rx_phase_e        phase_q, phase_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  logic             running_q, running_d;
  logic [DRN_W-1:0] cnt_q, cnt_d;
  logic [DRN_W-1:0] lim_q, lim_d;

  // Result register
  logic              ovalid_q, ovalid_d;
  logic              o_send_q, o_send_d;
  logic [BYTE_W-1:0] o_txb_q, o_txb_d;
  logic              o_rv_q, o_rv_d;
  logic [BYTE_W-1:0] o_rb_q, o_rb_d;
  logic              o_acc_q, o_acc_d;
  logic              o_last_q, o_last_d;
  logic              o_busy_q, o_busy_d;
  rx_phase_e         o_stat_q, o_stat_d;

  // RAM ports
  logic              rx_we, tx_we;
  logic [RX_AW-1:0]  rx_tail;
  logic [TX_AW-1:0]  tx_tail;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;
  logic [RX_CW:0]    rx_tail_sum;
  logic [TX_CW:0]    tx_tail_sum;

  // Step helpers
  logic              out_free;
  logic [TX_CW-1:0]  tx_fill_pushed;
  logic [BYTE_W-1:0] pop_byte;
  logic              send;
  logic              acc;
  logic [LEN_W-1:0]  len_sat;

  assign out_free = !ovalid_q || out_tready_i;

  assign rx_tail_sum = (RX_CW+1)'(rx_head_q) + (RX_CW+1)'(rx_fill_q);
  assign tx_tail_sum = (TX_CW+1)'(tx_head_q) + (TX_CW+1)'(tx_fill_q);
  assign rx_tail = (rx_tail_sum >= (RX_CW+1)'(RX_DEPTH)) ?
                   RX_AW'(rx_tail_sum - (RX_CW+1)'(RX_DEPTH)) : RX_AW'(rx_tail_sum);
  assign tx_tail = (tx_tail_sum >= (TX_CW+1)'(TX_DEPTH)) ?
                   TX_AW'(tx_tail_sum - (TX_CW+1)'(TX_DEPTH)) : TX_AW'(tx_tail_sum);

  // Read length: zero counts as one, clamp to the drain limit
  always_comb begin
    if (len_q == '0) begin
      len_sat = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_READ)) begin
      len_sat = LEN_W'(MAX_READ);
    end else begin
      len_sat = len_q;
    end
  end

  assign status_o.is_drain_read = (kind_q == KIND_HOST_RD) && (phase_q == RX_DONE) &&
                                  (rx_fill_q != '0);
  assign status_o.drain_last    = ((cnt_q + DRN_W'(1)) == lim_q) ||
                                  (rx_fill_q == RX_CW'(1));
  assign status_o.out_free      = out_free;

  always_comb begin
    rx_head_d      = rx_head_q;
    rx_fill_d      = rx_fill_q;
    tx_head_d      = tx_head_q;
    tx_fill_d      = tx_fill_q;
    phase_d        = phase_q;
    gap_d          = gap_q;
    running_d      = running_q;
    cnt_d          = cnt_q;
    lim_d          = lim_q;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    send           = 1'b0;
    acc            = 1'b0;
    pop_byte       = '0;
    tx_fill_pushed = tx_fill_q;
    ovalid_d       = ovalid_q && !out_tready_i;
    o_send_d       = o_send_q;
    o_txb_d        = o_txb_q;
    o_rv_d         = o_rv_q;
    o_rb_d         = o_rb_q;
    o_acc_d        = o_acc_q;
    o_last_d       = o_last_q;
    o_busy_d       = o_busy_q;
    o_stat_d       = o_stat_q;

    if (cmd_i.exec) begin
      unique case (kind_q)
        KIND_RX_BYTE: begin
          if (cfg_i.rx_en) begin
            if (rx_fill_q < RX_CW'(RX_DEPTH)) begin
              rx_we     = 1'b1;
              rx_fill_d = rx_fill_q + RX_CW'(1);
            end
            gap_d   = cfg_i.idle_gap;
            phase_d = RX_RECV;
          end
        end
        KIND_TICK: begin
          if (phase_q == RX_RECV) begin
            if (gap_q != '0) begin
              gap_d = gap_q - GAP_W'(1);
            end else begin
              phase_d = RX_DONE;
            end
          end
        end
        KIND_TX_WRITE: begin
          if (tx_fill_q < TX_CW'(TX_DEPTH)) begin
            tx_we          = 1'b1;
            acc            = 1'b1;
            tx_fill_pushed = tx_fill_q + TX_CW'(1);
          end
          tx_fill_d = tx_fill_pushed;
          if (!running_q && (tx_fill_pushed != '0)) begin
            // An empty queue pops the byte just written
            pop_byte  = (tx_fill_q == '0) ? data_q : tx_rdata;
            send      = 1'b1;
            running_d = 1'b1;
            tx_head_d = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + TX_AW'(1);
            tx_fill_d = tx_fill_pushed - TX_CW'(1);
          end
        end
        KIND_HOST_RD: begin
          // Finished frame with nothing queued: back to idle, no byte
          if (phase_q == RX_DONE) begin
            phase_d = RX_IDLE;
          end
        end
        KIND_TX_DONE: begin
          if (cfg_i.tx_en) begin
            if (tx_fill_q != '0) begin
              pop_byte  = tx_rdata;
              send      = 1'b1;
              running_d = 1'b1;
              tx_head_d = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + TX_AW'(1);
              tx_fill_d = tx_fill_q - TX_CW'(1);
            end else begin
              running_d = 1'b0;
            end
          end
        end
        default: begin
          // Unknown kind: status only
        end
      endcase
      ovalid_d = 1'b1;
      o_send_d = send;
      o_txb_d  = send ? pop_byte : '0;
      o_rv_d   = 1'b0;
      o_rb_d   = '0;
      o_acc_d  = acc;
      o_last_d = 1'b1;
      o_busy_d = running_d;
      o_stat_d = phase_d;
    end

    if (cmd_i.start_drain) begin
      phase_d = RX_IDLE;
      cnt_d   = '0;
      lim_d   = DRN_W'(len_sat);
    end

    if (cmd_i.drain_pop) begin
      rx_head_d = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + RX_AW'(1);
      rx_fill_d = rx_fill_q - RX_CW'(1);
      cnt_d     = cnt_q + DRN_W'(1);
      ovalid_d  = 1'b1;
      o_send_d  = 1'b0;
      o_txb_d   = '0;
      o_rv_d    = 1'b1;
      o_rb_d    = rx_rdata;
      o_acc_d   = 1'b0;
      o_last_d  = status_o.drain_last;
      o_busy_d  = running_q;
      o_stat_d  = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_fill_q <= '0;
      tx_head_q <= '0;
      tx_fill_q <= '0;
      phase_q   <= RX_IDLE;
      gap_q     <= '0;
      running_q <= 1'b0;
      cnt_q     <= '0;
      lim_q     <= '0;
      ovalid_q  <= 1'b0;
      kind_q    <= '0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_fill_q <= rx_fill_d;
      tx_head_q <= tx_head_d;
      tx_fill_q <= tx_fill_d;
      phase_q   <= phase_d;
      gap_q     <= gap_d;
      running_q <= running_d;
      cnt_q     <= cnt_d;
      lim_q     <= lim_d;
      ovalid_q  <= ovalid_d;
      if (cmd_i.accept) begin
        kind_q <= in_tuser_i[KIND_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= in_tdata_i[BYTE_W-1:0];
      len_q  <= in_tdata_i[BYTE_W +: LEN_W];
    end
    o_send_q <= o_send_d;
    o_txb_q  <= o_txb_d;
    o_rv_q   <= o_rv_d;
    o_rb_q   <= o_rb_d;
    o_acc_q  <= o_acc_d;
    o_last_q <= o_last_d;
    o_busy_q <= o_busy_d;
    o_stat_q <= o_stat_d;
  end

  // Read ports follow the next head, so read data always shows the current head
  ubfit_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail),
    .wdata_i (data_q),
    .raddr_i (rx_head_d),
    .rdata_o (rx_rdata)
  );

  ubfit_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail),
    .wdata_i (data_q),
    .raddr_i (tx_head_d),
    .rdata_o (tx_rdata)
  );

  assign out_tvalid_o = ovalid_q;
  assign out_tlast_o  = o_last_q;
  assign out_tuser_o  = {o_rv_q, o_send_q};
  assign out_tdata_o  = {4'b0, o_stat_q, o_busy_q, o_acc_q, o_rb_q, o_txb_q};

endmodule : ubfit_dp
`default_nettype wire

// ----- rtl/uart_buffered_frame_idle_timeout_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_buffered_frame_idle_timeout_top
// Buffered UART core with end-of-frame detection by a quiet gap on the line.
// ----------------------------------------------------------------------------
// Each item carries an event: a received line byte, a millisecond tick, a host
// write byte, a host read, or a transmit-complete. Received bytes go into a
// 256-byte receive queue (dropped when full) and reload the gap timer; ticks
// count the gap down and mark the frame finished. A host read drains up to
// read_len bytes (at most 64) only from a finished frame, one result per byte,
// then returns the receive status to idle. Host write bytes go into a 256-byte
// transmit queue and start the transmitter when it is idle. Every item except a
// draining read gives one result; tlast marks the final result of an item.
// Timing: an item is taken, then executed once the result register is free. A
// draining read has an extra setup step, then hands out one byte per cycle while
// the result register is free, paced by the registered read port of the receive
// store. The block accepts a new item while the last result still waits in the
// output register. Both stores come out of reset undefined and need no clearing
// pass; the queue pointers alone decide what is valid.
// ----------------------------------------------------------------------------
module uart_buffered_frame_idle_timeout_top
  import ubfit_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready,
  // Event items
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // data_byte[7:0], read_len[14:8]
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // kind[2:0]
  // Results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [M_TDATA_W-1:0] m_axis_tdata,  // tx_byte[7:0], read_byte[15:8],
                                                   // write_accepted[16], tx_busy[17],
                                                   // rx_status[19:18]
  output logic      [M_TUSER_W-1:0] m_axis_tuser,  // tx_send[0], read_valid[1]
  output logic                      m_axis_tlast   // last
);

  cfg_t       cfg_q, cfg_d;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // Register file: written in the access phase, pready tied high
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IDLE_GAP: cfg_d.idle_gap = pwdata[GAP_W-1:0];
        REG_RX_EN:    cfg_d.rx_en    = pwdata[0];
        REG_TX_EN:    cfg_d.tx_en    = pwdata[0];
        default:      cfg_d          = cfg_q;  // no register here, drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_gap <= IDLE_GAP_RST;
      cfg_q.rx_en    <= 1'b1;
      cfg_q.tx_en    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IDLE_GAP: prdata = PDATA_W'(cfg_q.idle_gap);
      REG_RX_EN:    prdata = PDATA_W'(cfg_q.rx_en);
      REG_TX_EN:    prdata = PDATA_W'(cfg_q.tx_en);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: take an item, execute it, or drain a host read
  ubfit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Queues, gap timer and result register
  ubfit_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser),
    .out_tlast_o  (m_axis_tlast)
  );

endmodule : uart_buffered_frame_idle_timeout_top
`default_nettype wire

// ----- rtl/ubfit_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubfit_checker
// Port-level checks of the buffered UART core, bound to the top level.
// ----------------------------------------------------------------------------
module ubfit_checker
  import ubfit_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [M_TUSER_W-1:0] m_axis_tuser,
  input wire logic                 m_axis_tlast
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one executes");

  // A sent byte leaves the transmitter busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[17])
    else $error("byte sent with transmitter idle");

  // A drained byte comes with idle receive status and no transmit activity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[19:18] == RX_IDLE) && !m_axis_tuser[0] && !m_axis_tdata[16])
    else $error("drained byte with wrong status");

  // A result that is not last is a drained byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[1])
    else $error("non-final result is not a read byte");

endmodule : ubfit_checker

bind uart_buffered_frame_idle_timeout_top ubfit_checker u_ubfit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- verif/uart_buffered_frame_idle_timeout_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_buffered_frame_idle_timeout_top_test
// Self-checking bench for the buffered UART core with idle-gap frame end.
// ----------------------------------------------------------------------------
// Events enter on the slave stream. A scoreboard tracks both byte queues, the
// gap timer, the receive phase and the transmitter flag, and expands every
// accepted item into the results it must produce. Every result leaving on the
// master stream is checked field by field against the oldest expectation.
// Stimulus: a directed opening, then mixed frames, transmit bursts and noise
// under four register settings, with the receive queue driven past full once.
// ----------------------------------------------------------------------------
module uart_buffered_frame_idle_timeout_top_test;
  import ubfit_pkg::*;

  // Event kinds the block does not define; it must answer with a status result
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                tx_send;
    logic [BYTE_W-1:0]   tx_byte;
    logic                read_valid;
    logic [BYTE_W-1:0]   read_byte;
    logic                write_accepted;
    logic                last;
    logic                tx_busy;
    logic [STATUS_W-1:0] rx_status;
  } uart_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the core state and holds the results still owed
  // --------------------------------------------------------------------------
  class uart_core_scoreboard;
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [RX_AW-1:0]  rx_rd;
    logic [TX_AW-1:0]  tx_rd;
    int unsigned       rx_cnt;
    int unsigned       tx_cnt;
    rx_phase_e         rx_ph;
    logic [GAP_W-1:0]  gap_left;
    logic              tx_on;
    logic [GAP_W-1:0]  gap_reload;
    logic              rx_en;
    logic              tx_en;
    uart_result_t      owed_q[$];
    int unsigned       errs;

    function new();
      rx_rd      = '0;
      tx_rd      = '0;
      rx_cnt     = 0;
      tx_cnt     = 0;
      rx_ph      = RX_IDLE;
      gap_left   = '0;
      tx_on      = 1'b0;
      gap_reload = IDLE_GAP_RST;
      rx_en      = 1'b1;
      tx_en      = 1'b1;
      errs       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_IDLE_GAP: gap_reload = val[GAP_W-1:0];
        REG_RX_EN:    rx_en = val[0];
        REG_TX_EN:    tx_en = val[0];
        default: ;
      endcase
    endfunction

    function void owe(logic send, logic [7:0] txb, logic rv, logic [7:0] rb,
                      logic acc, logic lst);
      uart_result_t r;
      r.tx_send        = send;
      r.tx_byte        = txb;
      r.read_valid     = rv;
      r.read_byte      = rb;
      r.write_accepted = acc;
      r.last           = lst;
      r.tx_busy        = tx_on;
      r.rx_status      = rx_ph;
      owed_q.push_back(r);
    endfunction

    // Pop the next transmit byte; report whether there was one
    function logic take_tx(output logic [7:0] b);
      b = '0;
      if (tx_cnt == 0) return 1'b0;
      b = tx_mem[tx_rd];
      tx_rd++;
      tx_cnt--;
      return 1'b1;
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [7:0] data, logic [6:0] len);
      logic             send, acc;
      logic [7:0]       b;
      logic [RX_AW-1:0] rx_wr;
      logic [TX_AW-1:0] tx_wr;
      int unsigned      lim, n;
      uart_result_t     tail;
      send = 1'b0;
      acc  = 1'b0;
      b    = '0;
      case (kind)
        KIND_RX_BYTE: begin
          if (rx_en) begin
            // full queue: drop the byte but still restart the gap
            if (rx_cnt < RX_DEPTH) begin
              rx_wr = rx_rd + RX_AW'(rx_cnt);
              rx_mem[rx_wr] = data;
              rx_cnt++;
            end
            gap_left = gap_reload;
            rx_ph    = RX_RECV;
          end
        end
        KIND_TICK: begin
          if (rx_ph == RX_RECV) begin
            if (gap_left != 0) gap_left--;
            else rx_ph = RX_DONE;
          end
        end
        KIND_TX_WRITE: begin
          if (tx_cnt < TX_DEPTH) begin
            tx_wr = tx_rd + TX_AW'(tx_cnt);
            tx_mem[tx_wr] = data;
            tx_cnt++;
            acc = 1'b1;
          end
          // start at once when the line is idle, even after a drop
          if (!tx_on && take_tx(b)) begin
            send  = 1'b1;
            tx_on = 1'b1;
          end
        end
        KIND_HOST_RD: begin
          if (rx_ph == RX_DONE) begin
            lim = (len == 0) ? 1 : len;
            if (lim > MAX_READ) lim = MAX_READ;
            rx_ph = RX_IDLE;
            n = 0;
            while (n < lim && rx_cnt != 0) begin
              b = rx_mem[rx_rd];
              rx_rd++;
              rx_cnt--;
              n++;
              owe(1'b0, '0, 1'b1, b, 1'b0, 1'b0);
            end
            if (n != 0) begin
              tail = owed_q.pop_back();
              tail.last = 1'b1;
              owed_q.push_back(tail);
              return;
            end
          end
        end
        KIND_TX_DONE: begin
          if (tx_en) begin
            if (take_tx(b)) begin
              send  = 1'b1;
              tx_on = 1'b1;
            end else begin
              tx_on = 1'b0;
            end
          end
        end
        default: ;
      endcase
      owe(send, send ? b : 8'h00, 1'b0, 8'h00, acc, 1'b1);
    endfunction

    task report(string what);
      errs++;
      if (errs <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(uart_result_t got);
      uart_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = owed_q.pop_front();
      if (got.tx_send !== want.tx_send)
        report($sformatf("tx_send got %b want %b", got.tx_send, want.tx_send));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
      if (got.read_valid !== want.read_valid)
        report($sformatf("read_valid got %b want %b", got.read_valid, want.read_valid));
      if (got.read_byte !== want.read_byte)
        report($sformatf("read_byte got %h want %h", got.read_byte, want.read_byte));
      if (got.write_accepted !== want.write_accepted)
        report($sformatf("write_accepted got %b want %b",
                         got.write_accepted, want.write_accepted));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
      if (got.tx_busy !== want.tx_busy)
        report($sformatf("tx_busy got %b want %b", got.tx_busy, want.tx_busy));
      if (got.rx_status !== want.rx_status)
        report($sformatf("rx_status got %0d want %0d", got.rx_status, want.rx_status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // data_byte[7:0], read_len[14:8]
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // kind[2:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // tx_byte[7:0], read_byte[15:8],
                                            // write_accepted[16], tx_busy[17],
                                            // rx_status[19:18]
  logic [M_TUSER_W-1:0] m_axis_tuser;       // tx_send[0], read_valid[1]
  logic                 m_axis_tlast;

  uart_buffered_frame_idle_timeout_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  uart_core_scoreboard sb = new();

  // Idle odds in percent per cycle, set per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_cnt = 0;
  // Long receiver hold-off: raised by the main sequence, counted down below
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side: drive tready at the falling edge, check at the rising edge
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_left = 180;
        hold_go   = 1'b0;
      end
      if (hold_left != 0) begin
        // hold off long enough for the core to back up and stall its input
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    uart_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tx_send        = m_axis_tuser[0];
      got.read_valid     = m_axis_tuser[1];
      got.tx_byte        = m_axis_tdata[7:0];
      got.read_byte      = m_axis_tdata[15:8];
      got.write_accepted = m_axis_tdata[16];
      got.tx_busy        = m_axis_tdata[17];
      got.rx_status      = m_axis_tdata[19:18];
      got.last           = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task reg_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task send_item(logic [KIND_W-1:0] kind, logic [7:0] data, logic [6:0] len);
    // random gap before the item, one decision per cycle
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len, data};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, data, len);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Drop valid, let every owed result drain, then let the core settle
  task wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Read lengths: mostly short, with zero, the cap and past the cap mixed in
  function logic [6:0] read_len_pick();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(MAX_READ);
    if (r == 2) return 7'($urandom_range(MAX_READ + 1, 127));
    return 7'($urandom_range(1, 12));
  endfunction

  // Mixed traffic: whole frames ending in a read, transmit bursts, and noise
  task run_mix(int unsigned n_items);
    int unsigned stop_at, pick, cnt, ticks, i;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cnt = $urandom_range(1, 8);
        for (i = 0; i < cnt; i++)
          send_item(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        // enough ticks to finish the frame for gaps up to 16, sometimes short of it
        ticks = (sb.gap_reload <= 16) ? sb.gap_reload + 1 : $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, ticks + 1);
        for (i = 0; i < ticks; i++)
          send_item(KIND_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 4) != 0)
          send_item(KIND_HOST_RD, 8'($urandom_range(0, 255)), read_len_pick());
      end else if (pick < 70) begin
        cnt = $urandom_range(1, 4);
        for (i = 0; i < cnt; i++)
          send_item(KIND_TX_WRITE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
        cnt = cnt + $urandom_range(0, 2);
        for (i = 0; i < cnt; i++)
          send_item(KIND_TX_DONE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      end else begin
        send_item(KIND_W'($urandom_range(0, KIND_SPARE_HI)), 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned i, n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: reset register values, sender idles less than receiver
    send_idle_pct = 34;
    recv_idle_pct = 51;

    // Directed opening: reads, ticks and completions with nothing going on
    send_item(KIND_HOST_RD, 8'h00, 7'(MAX_READ));
    send_item(KIND_TICK, 8'h00, 7'd0);
    send_item(KIND_TX_DONE, 8'h00, 7'd0);
    send_item(KIND_SPARE_HI, 8'hFF, 7'h7F);
    send_item(KIND_SPARE_LO, 8'h5A, 7'd1);
    // a frame, read too early, then finished by the gap
    send_item(KIND_RX_BYTE, 8'h00, 7'd0);
    send_item(KIND_RX_BYTE, 8'hFF, 7'h7F);
    send_item(KIND_HOST_RD, 8'h00, 7'd3);
    for (i = 0; i <= IDLE_GAP_RST; i++) send_item(KIND_TICK, 8'h00, 7'd0);
    // zero length reads one byte and leaves one behind
    send_item(KIND_HOST_RD, 8'h00, 7'd0);
    send_item(KIND_RX_BYTE, 8'h81, 7'd0);
    for (i = 0; i <= IDLE_GAP_RST; i++) send_item(KIND_TICK, 8'h00, 7'd0);
    // length past the cap drains the rest
    send_item(KIND_HOST_RD, 8'h00, 7'h7F);
    // transmit start, queued byte, then the line goes idle
    send_item(KIND_TX_WRITE, 8'h00, 7'd0);
    send_item(KIND_TX_WRITE, 8'hFF, 7'd0);
    send_item(KIND_TX_DONE, 8'h00, 7'd0);
    send_item(KIND_TX_DONE, 8'h00, 7'd0);

    // stall the result side for a long stretch while items keep coming
    hold_go = 1'b1;
    run_mix(30);
    wait_idle();

    // Phase 2: zero gap, completions ignored; overflow the receive queue
    reg_write(REG_IDLE_GAP, 32'd0);
    reg_write(REG_RX_EN, 32'd1);
    reg_write(REG_TX_EN, 32'd0);
    n = RX_DEPTH - sb.rx_cnt + 4;
    for (i = 0; i < n; i++)
      send_item(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    send_item(KIND_TICK, 8'h00, 7'd0);
    for (i = 0; i < 3; i++) begin
      send_item(KIND_HOST_RD, 8'($urandom_range(0, 255)), 7'(MAX_READ));
      send_item(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 7'd0);
      send_item(KIND_TICK, 8'h00, 7'd0);
    end
    send_item(KIND_HOST_RD, 8'h00, 7'(MAX_READ));
    run_mix(10);
    wait_idle();

    // Phase 3: largest gap, received bytes ignored
    send_idle_pct = 51;
    recv_idle_pct = 34;
    reg_write(REG_IDLE_GAP, 32'd255);
    reg_write(REG_RX_EN, 32'd0);
    reg_write(REG_TX_EN, 32'd1);
    run_mix(20);
    wait_idle();

    // Phase 4: short gap, everything enabled, no random idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(REG_IDLE_GAP, 32'($urandom_range(1, 4)));
    reg_write(REG_RX_EN, 32'd1);
    reg_write(REG_TX_EN, 32'd1);
    hold_go = 1'b1;
    run_mix(25);
    wait_idle();

    if (sb.errs == 0 && sb.owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
